/* src/ole_pkg.sv */
// Shared types and constants for the ordered list engine.
package ole_pkg;

  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 8;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_APPEND    = 3'd1,
    REQ_INS_SORT  = 3'd2,
    REQ_INS_POS   = 3'd3,
    REQ_DEL_FRONT = 3'd4,
    REQ_DEL_LAST  = 3'd5,
    REQ_DEL_VALUE = 3'd6,
    REQ_DEL_POS   = 3'd7
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FIN
  } state_t;

endpackage

/* src/ole_mem.sv */
// Value store: one write port and one registered read port.
module ole_mem
  import ole_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/ordered_list_engine.sv */
// Ordered list engine: request decode, memory walk sequencer and result register.
// An item that decode alone settles (full, empty or a bad position) goes straight to the
// result; an append or a delete at the back moves no other entry. Searches and shifts walk
// the value memory one entry per cycle through its single read port. Items
// are handled one at a time; a result waits in the output register while the next item
// is taken. Reset clears the length to zero; the value memory is not cleared.
module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // item_value[31:0], position[39:32]
  input  logic [REQ_W-1:0]       in_tuser,   // req_type[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // removed_value[31:0], status[33:32],
                                             // length[41:34], zero[47:42]
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = POS_W + 1;

  state_t              state_r, state_nxt;
  req_type_t           op_r, op_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       at_r, at_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [DATA_W-1:0]   removed_r, removed_nxt;
  status_t             status_r, status_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [CW-1:0]       rd_idx;
  logic [CW-1:0]       wr_idx;
  logic                wr_en;
  logic [DATA_W-1:0]   wr_data;
  logic [DATA_W-1:0]   rd_data;
  logic                in_acc;
  logic                hit;
  req_type_t           in_op;
  logic [DATA_W-1:0]   in_val;
  logic [POS_W-1:0]    in_pos;
  logic [PW-1:0]       pos_ext;
  logic [PW-1:0]       cnt_ext;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = req_type_t'(in_tuser);
  assign in_val    = in_tdata[DATA_W-1:0];
  assign in_pos    = in_tdata[DATA_W+POS_W-1:DATA_W];
  assign pos_ext   = {1'b0, in_pos};
  assign cnt_ext   = PW'(cnt_r);

  assign hit = (op_r == REQ_INS_SORT) ? ($signed(val_r) < $signed(rd_data))
                                      : (rd_data == val_r);

  ole_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_data)
  );

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    val_nxt      = val_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    at_nxt       = at_r;
    ptr_nxt      = ptr_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    removed_nxt  = removed_r;
    status_nxt   = status_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    rd_idx       = ptr_r;
    wr_en        = 1'b0;
    wr_idx       = at_r;
    wr_data      = val_r;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_op;
          val_nxt     = in_val;
          pos_nxt     = in_pos;
          removed_nxt = '0;
          status_nxt  = STAT_OK;
          ptr_nxt     = '0;
          at_nxt      = '0;
          if (in_op == REQ_INS_FRONT || in_op == REQ_APPEND ||
              in_op == REQ_INS_SORT || in_op == REQ_INS_POS) begin
            if (cnt_r == CW'(CAPACITY)) begin
              status_nxt = STAT_FULL;
              state_nxt  = S_FIN;
            end else if (cnt_r == '0 || in_op == REQ_INS_FRONT) begin
              at_nxt    = '0;
              ptr_nxt   = cnt_r;
              state_nxt = S_SHIFT_UP;
            end else if (in_op == REQ_APPEND) begin
              at_nxt    = cnt_r;
              ptr_nxt   = cnt_r;
              state_nxt = S_SHIFT_UP;
            end else if (in_op == REQ_INS_SORT) begin
              state_nxt = S_SEARCH;
            end else if (pos_ext != '0 && pos_ext <= cnt_ext + PW'(1)) begin
              at_nxt    = CW'(pos_ext - PW'(1));
              ptr_nxt   = cnt_r;
              state_nxt = S_SHIFT_UP;
            end else begin
              status_nxt = STAT_NOTFOUND;
              state_nxt  = S_FIN;
            end
          end else if (cnt_r == '0) begin
            status_nxt = STAT_EMPTY;
            state_nxt  = S_FIN;
          end else if (in_op == REQ_DEL_FRONT) begin
            state_nxt = S_SHIFT_DN;
          end else if (in_op == REQ_DEL_LAST) begin
            at_nxt    = cnt_r - CW'(1);
            ptr_nxt   = cnt_r - CW'(1);
            state_nxt = S_SHIFT_DN;
          end else if (in_op == REQ_DEL_VALUE) begin
            state_nxt = S_SEARCH;
          end else if (pos_ext != '0 && pos_ext <= cnt_ext) begin
            at_nxt    = CW'(pos_ext - PW'(1));
            ptr_nxt   = CW'(pos_ext - PW'(1));
            state_nxt = S_SHIFT_DN;
          end else begin
            status_nxt = STAT_NOTFOUND;
            state_nxt  = S_FIN;
          end
        end
      end

      S_SEARCH: begin
        if (ptr_r < cnt_r) begin
          rd_idx     = ptr_r;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r;
          ptr_nxt    = ptr_r + CW'(1);
        end
        if (rd_vld_r) begin
          if (hit) begin
            rd_vld_nxt = 1'b0;
            at_nxt     = rd_idx_r;
            if (op_r == REQ_INS_SORT) begin
              ptr_nxt   = cnt_r;
              state_nxt = S_SHIFT_UP;
            end else begin
              ptr_nxt   = rd_idx_r;
              state_nxt = S_SHIFT_DN;
            end
          end else if (rd_idx_r == cnt_r - CW'(1)) begin
            rd_vld_nxt = 1'b0;
            if (op_r == REQ_INS_SORT) begin
              at_nxt    = cnt_r;
              ptr_nxt   = cnt_r;
              state_nxt = S_SHIFT_UP;
            end else begin
              status_nxt = STAT_NOTFOUND;
              state_nxt  = S_FIN;
            end
          end
        end
      end

      S_SHIFT_UP: begin
        if (rd_vld_r) begin
          wr_en   = 1'b1;
          wr_idx  = rd_idx_r + CW'(1);
          wr_data = rd_data;
        end
        if (ptr_r > at_r) begin
          rd_idx     = ptr_r - CW'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r - CW'(1);
          ptr_nxt    = ptr_r - CW'(1);
        end else if (!rd_vld_r) begin
          wr_en     = 1'b1;
          wr_idx    = at_r;
          wr_data   = val_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_FIN;
        end
      end

      S_SHIFT_DN: begin
        if (rd_vld_r) begin
          if (rd_idx_r == at_r) begin
            if (op_r == REQ_DEL_FRONT || op_r == REQ_DEL_LAST) begin
              removed_nxt = rd_data;
            end
          end else begin
            wr_en   = 1'b1;
            wr_idx  = rd_idx_r - CW'(1);
            wr_data = rd_data;
          end
        end
        if (ptr_r < cnt_r) begin
          rd_idx     = ptr_r;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r;
          ptr_nxt    = ptr_r + CW'(1);
        end else if (!rd_vld_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {(OUT_TDATA_W - DATA_W - STAT_W - LEN_W)'(0),
                          LEN_W'(cnt_r), status_r, removed_r};
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    pos_r      <= pos_nxt;
    at_r       <= at_nxt;
    ptr_r      <= ptr_nxt;
    rd_idx_r   <= rd_idx_nxt;
    removed_r  <= removed_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("List length exceeds capacity.");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_idx < CW'(CAPACITY)) && (wr_idx <= cnt_r))
    else $error("Write outside the occupied region.");

  a_rd_only_walking: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SEARCH || state_r == S_SHIFT_UP ||
                  state_r == S_SHIFT_DN))
    else $error("Pending read outside a memory walk.");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("Accepted item did not start processing.");

  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (state_r == S_FIN))
    else $error("Length changed outside completion.");

endmodule
